// ----- sv/lahpc_pkg.sv -----
// shared types, codes and reset values of the rail homing and position controller
// no dependencies; imported by lahpc_div and the top level
package lahpc_pkg;

	localparam int CountWidthDef = 32;
	localparam int QuoWidth      = 25;

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_INIT    = 3'd1;
	localparam logic [2:0] OP_SETPOS  = 3'd2;
	localparam logic [2:0] OP_STOP    = 3'd3;
	localparam logic [2:0] OP_RESET   = 3'd4;

	localparam logic [1:0] PH_RETRACT = 2'd0;
	localparam logic [1:0] PH_EXTEND  = 2'd1;
	localparam logic [1:0] PH_HOME    = 2'd2;

	localparam logic [2:0] CFG_CAL_SPEED = 3'd0;
	localparam logic [2:0] CFG_MAX_SPEED = 3'd1;
	localparam logic [2:0] CFG_GAIN      = 3'd2;
	localparam logic [2:0] CFG_TOLERANCE = 3'd3;
	localparam logic [2:0] CFG_STALL_TO  = 3'd4;

	localparam logic [14:0] CalSpeedRst  = 15'd9830;
	localparam logic [14:0] MaxSpeedRst  = 15'd26214;
	localparam logic [15:0] GainRst      = 16'd768;
	localparam logic [15:0] TolRst       = 16'd655;
	localparam logic [15:0] StallToRst   = 16'd500;

	localparam logic [16:0] PosOne       = 17'h10000;
	localparam logic [QuoWidth-1:0] ErrClamp = QuoWidth'(25'h100_0000);

	typedef enum logic [2:0] {
		MODE_UNINIT = 3'd0,
		MODE_CAL    = 3'd1,
		MODE_IDLE   = 3'd2,
		MODE_MOVING = 3'd3,
		MODE_FAULT  = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_OP,
		S_TGT,
		S_TGT_ADD,
		S_ERR_START,
		S_ERR_DIV,
		S_GAIN,
		S_DRIVE,
		S_POS,
		S_POS_DIV,
		S_OUT
	} seq_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

endpackage

// ----- sv/linear_axis_homing_position_controller_unit.sv -----
// rail homing and proportional position controller, top level
// depends on lahpc_pkg and lahpc_div (shared serial divider)
//
// channel   direction  handshake           payload
// in        sink       in_valid/in_stall   op, encoder_count, switches, now_ms, target_position
// out       source     out_valid/out_stall rail_drive, mode, is_calibrated, position
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// a plain op skips the divider while uncalibrated and runs it for position once calibrated
// a moving tick runs the shared 25-step divider for the error and for position
// in_stall is high from acceptance until the result is loaded into the output register
// a stalled output only holds the sequencer in its last step; the next request waits behind it
// reset clears mode, phase, ends, timers and drive; configuration returns to defaults
module linear_axis_homing_position_controller_unit #(
	parameter int COUNT_WIDTH = lahpc_pkg::CountWidthDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic signed [31:0] encoder_count,
	input  logic               retract_switch,
	input  logic               extend_switch,
	input  logic [31:0]        now_ms,
	input  logic [16:0]        target_position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] rail_drive,
	output logic [2:0]         mode,
	output logic               is_calibrated,
	output logic [16:0]        position,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import lahpc_pkg::*;

	localparam int CW = COUNT_WIDTH;
	localparam int DW = CW + 1;

	// configuration registers
	logic [14:0] cal_speed_q;
	logic [14:0] max_speed_q;
	logic [15:0] gain_q;
	logic [15:0] tol_q;
	logic [15:0] stall_to_q;

	// architectural state
	mode_t              mode_q, mode_d;
	logic [1:0]         phase_q, phase_d;
	logic               tried_q, tried_d;
	logic               cal_q, cal_d;
	logic [16:0]        setpt_q, setpt_d;
	logic signed [CW-1:0] low_q, low_d;
	logic signed [CW-1:0] high_q, high_d;
	logic signed [CW-1:0] last_cnt_q, last_cnt_d;
	logic [31:0]        last_t_q, last_t_d;
	logic signed [15:0] drive_q, drive_d;

	// sequencer and latched request
	seq_t               seq_q, seq_d;
	logic [2:0]         op_q;
	logic signed [CW-1:0] cur_q;
	logic               ret_q, ext_q;
	logic [31:0]        now_q;
	logic [16:0]        tgt_q;

	// working registers
	logic [DW-1:0]      diff_q, diff_d;
	logic [CW+16:0]     tprod_q, tprod_d;
	logic [QuoWidth-1:0] eabs_q, eabs_d;
	logic               eneg_q, eneg_d;
	logic [40:0]        gprod_q, gprod_d;
	logic               pneg_q, pneg_d;
	logic [16:0]        pos_q, pos_d;

	// output register
	logic               out_valid_q;
	logic signed [15:0] out_drive_q;
	logic [2:0]         out_mode_q;
	logic               out_cal_q;
	logic [16:0]        out_pos_q;
	logic               out_load;

	// divider hookup
	logic               div_start;
	logic [CW+16:0]     div_num;
	logic [DW-1:0]      div_den;
	logic [QuoWidth-1:0] div_quo;
	div_stat_t          div_stat;
	logic [QuoWidth-1:0] qsat;

	// helpers
	logic               in_acc;
	logic [DW-1:0]      rng;
	logic               rng_pos;
	logic [DW-1:0]      rng_abs;
	logic [DW-1:0]      diff_abs;
	logic [DW-1:0]      pdiff;
	logic [DW-1:0]      pdiff_abs;
	logic [31:0]        lc;
	logic               stalled;
	logic [31:0]        pmag;
	logic [14:0]        lim;
	logic [14:0]        psat;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (seq_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// range of the rail in counts, one bit wider than a count
	assign rng     = {high_q[CW-1], high_q} - {low_q[CW-1], low_q};
	assign rng_pos = !rng[DW-1] && (rng != '0);
	assign rng_abs = rng[DW-1] ? (~rng + 1'b1) : rng;

	assign diff_abs  = diff_q[DW-1] ? (~diff_q + 1'b1) : diff_q;
	assign pdiff     = {cur_q[CW-1], cur_q} - {low_q[CW-1], low_q};
	assign pdiff_abs = pdiff[DW-1] ? (~pdiff + 1'b1) : pdiff;

	// divider quotient saturated on overflow
	assign qsat = div_stat.ovf ? '1 : div_quo;

	// stall timer sees the count update of this tick
	assign lc      = (cur_q != last_cnt_q) ? now_q : last_t_q;
	assign stalled = (now_q - lc) >= {16'b0, stall_to_q};

	// proportional drive, saturated to the limit of the current mode
	assign pmag = gprod_q[40:9];
	assign lim  = (mode_q == MODE_CAL) ? cal_speed_q : max_speed_q;
	assign psat = (pmag > {17'b0, lim}) ? lim : pmag[14:0];

	assign out_load = (seq_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		seq_d      = seq_q;
		mode_d     = mode_q;
		phase_d    = phase_q;
		tried_d    = tried_q;
		cal_d      = cal_q;
		setpt_d    = setpt_q;
		low_d      = low_q;
		high_d     = high_q;
		last_cnt_d = last_cnt_q;
		last_t_d   = last_t_q;
		drive_d    = drive_q;
		diff_d     = diff_q;
		tprod_d    = tprod_q;
		eabs_d     = eabs_q;
		eneg_d     = eneg_q;
		gprod_d    = gprod_q;
		pneg_d     = pneg_q;
		pos_d      = pos_q;
		div_start  = 1'b0;
		div_num    = '0;
		div_den    = '0;

		unique case (seq_q)
			S_IDLE: begin
				if (in_acc) begin
					seq_d = S_OP;
				end
			end
			S_OP: begin
				seq_d = S_POS;
				unique case (op_q)
					OP_TICK: begin
						// hard stops first
						if (mode_q != MODE_UNINIT) begin
							if (ret_q && drive_q[15]) begin
								drive_d = '0;
							end
							if (ext_q && !drive_q[15] && drive_q != '0) begin
								drive_d = '0;
							end
						end
						if (mode_q == MODE_CAL) begin
							if (cur_q != last_cnt_q) begin
								last_cnt_d = cur_q;
								last_t_d   = now_q;
							end
							unique case (phase_q)
								PH_EXTEND: begin
									if (ext_q) begin
										high_d = cur_q;
										if (cur_q <= low_q) begin
											drive_d = '0;
											mode_d  = MODE_FAULT;
										end else begin
											phase_d = PH_HOME;
											setpt_d = '0;
											drive_d = 16'd0 - {1'b0, cal_speed_q};
										end
									end else begin
										drive_d = {1'b0, cal_speed_q};
										if (stalled) begin
											drive_d = '0;
											mode_d  = MODE_FAULT;
										end
									end
								end
								PH_HOME: begin
									if (ret_q) begin
										cal_d   = 1'b1;
										drive_d = '0;
										mode_d  = MODE_IDLE;
									end else if (!rng_pos) begin
										drive_d = '0;
										mode_d  = MODE_FAULT;
									end else begin
										// error toward the retract end
										diff_d = {low_q[CW-1], low_q} - {cur_q[CW-1], cur_q};
										seq_d  = S_ERR_START;
									end
								end
								default: begin
									// seek retract, also for the unused phase code
									if (ret_q) begin
										low_d    = cur_q;
										phase_d  = PH_EXTEND;
										tried_d  = 1'b0;
										last_t_d = now_q;
										drive_d  = {1'b0, cal_speed_q};
									end else begin
										drive_d = 16'd0 - {1'b0, cal_speed_q};
										if (stalled) begin
											if (!tried_q) begin
												// switch may be missing, try the other way once
												tried_d  = 1'b1;
												low_d    = cur_q;
												phase_d  = PH_EXTEND;
												last_t_d = now_q;
												drive_d  = {1'b0, cal_speed_q};
											end else begin
												drive_d = '0;
												mode_d  = MODE_FAULT;
											end
										end
									end
								end
							endcase
						end else if (mode_q == MODE_MOVING) begin
							if (!rng_pos) begin
								drive_d = '0;
								mode_d  = MODE_FAULT;
							end else begin
								seq_d = S_TGT;
							end
						end
					end
					OP_INIT: begin
						if (mode_q != MODE_CAL) begin
							phase_d    = PH_RETRACT;
							tried_d    = 1'b0;
							last_cnt_d = cur_q;
							last_t_d   = now_q;
							mode_d     = MODE_CAL;
						end
					end
					OP_SETPOS: begin
						if (cal_q) begin
							setpt_d = (tgt_q > PosOne) ? PosOne : tgt_q;
							if (mode_q == MODE_IDLE || mode_q == MODE_MOVING) begin
								mode_d = MODE_MOVING;
							end
						end
					end
					OP_STOP: begin
						drive_d = '0;
						if (mode_q == MODE_MOVING) begin
							mode_d = MODE_IDLE;
						end
					end
					OP_RESET: begin
						drive_d = '0;
						mode_d  = MODE_UNINIT;
						cal_d   = 1'b0;
						setpt_d = '0;
						low_d   = '0;
						high_d  = '0;
					end
					default: begin
						// unknown op leaves the state alone
					end
				endcase
			end
			S_TGT: begin
				// range is positive here, so it fits in a count width
				tprod_d = setpt_q * rng[CW-1:0];
				seq_d   = S_TGT_ADD;
			end
			S_TGT_ADD: begin
				diff_d = {low_q[CW-1], low_q} + tprod_q[CW+16:16] - {cur_q[CW-1], cur_q};
				seq_d  = S_ERR_START;
			end
			S_ERR_START: begin
				div_start = 1'b1;
				div_num   = {diff_abs, 16'b0};
				div_den   = rng;
				seq_d     = S_ERR_DIV;
			end
			S_ERR_DIV: begin
				if (div_stat.done) begin
					eabs_d = (qsat > ErrClamp) ? ErrClamp : qsat;
					eneg_d = diff_q[DW-1];
					seq_d  = S_GAIN;
				end
			end
			S_GAIN: begin
				gprod_d = eabs_q * gain_q;
				seq_d   = S_DRIVE;
			end
			S_DRIVE: begin
				drive_d = eneg_q ? (16'd0 - {1'b0, psat}) : {1'b0, psat};
				if (eabs_q < QuoWidth'(tol_q)) begin
					// arrived: home completes calibration, a move ends
					if (mode_q == MODE_CAL) begin
						cal_d = 1'b1;
					end
					drive_d = '0;
					mode_d  = MODE_IDLE;
				end
				seq_d = S_POS;
			end
			S_POS: begin
				if (!cal_q || rng == '0) begin
					pos_d = '0;
					seq_d = S_OUT;
				end else begin
					div_start = 1'b1;
					div_num   = {pdiff_abs, 16'b0};
					div_den   = rng_abs;
					pneg_d    = pdiff[DW-1] ^ rng[DW-1];
					seq_d     = S_POS_DIV;
				end
			end
			S_POS_DIV: begin
				if (div_stat.done) begin
					if (pneg_q) begin
						pos_d = '0;
					end else begin
						pos_d = (qsat > QuoWidth'(PosOne)) ? PosOne : qsat[16:0];
					end
					seq_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_load) begin
					seq_d = S_IDLE;
				end
			end
			default: begin
				seq_d = S_IDLE;
			end
		endcase
	end

	// control state and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= S_IDLE;
			mode_q      <= MODE_UNINIT;
			phase_q     <= PH_RETRACT;
			tried_q     <= 1'b0;
			cal_q       <= 1'b0;
			setpt_q     <= '0;
			low_q       <= '0;
			high_q      <= '0;
			last_cnt_q  <= '0;
			last_t_q    <= '0;
			drive_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			seq_q      <= seq_d;
			mode_q     <= mode_d;
			phase_q    <= phase_d;
			tried_q    <= tried_d;
			cal_q      <= cal_d;
			setpt_q    <= setpt_d;
			low_q      <= low_d;
			high_q     <= high_d;
			last_cnt_q <= last_cnt_d;
			last_t_q   <= last_t_d;
			drive_q    <= drive_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_speed_q <= CalSpeedRst;
			max_speed_q <= MaxSpeedRst;
			gain_q      <= GainRst;
			tol_q       <= TolRst;
			stall_to_q  <= StallToRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CAL_SPEED: cal_speed_q <= cfg_data[14:0];
				CFG_MAX_SPEED: max_speed_q <= cfg_data[14:0];
				CFG_GAIN:      gain_q      <= cfg_data;
				CFG_TOLERANCE: tol_q       <= cfg_data;
				CFG_STALL_TO:  stall_to_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// latched request, working values and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= op;
			cur_q <= encoder_count[CW-1:0];
			ret_q <= retract_switch;
			ext_q <= extend_switch;
			now_q <= now_ms;
			tgt_q <= target_position;
		end
		diff_q  <= diff_d;
		tprod_q <= tprod_d;
		eabs_q  <= eabs_d;
		eneg_q  <= eneg_d;
		gprod_q <= gprod_d;
		pneg_q  <= pneg_d;
		pos_q   <= pos_d;
		if (out_load) begin
			out_drive_q <= drive_q;
			out_mode_q  <= mode_q;
			out_cal_q   <= cal_q;
			out_pos_q   <= pos_q;
		end
	end

	lahpc_div #(
		.CW(CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	assign out_valid     = out_valid_q;
	assign rail_drive    = out_drive_q;
	assign mode          = out_mode_q;
	assign is_calibrated = out_cal_q;
	assign position      = out_pos_q;

	// the rail is never driven before homing has been started
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_UNINIT) |-> (drive_q == '0))
		else $error("drive active while uninitialized");

	// normalized position stays within one
	assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == S_OUT) |-> (pos_q <= PosOne))
		else $error("position above one");

	// divider finishes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (seq_q == S_ERR_DIV || seq_q == S_POS_DIV))
		else $error("divider result with nobody waiting");

	// a held result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == S_OUT && out_valid_q && out_stall) |=> (seq_q == S_OUT))
		else $error("result loaded over a stalled one");

endmodule

// ----- sv/lahpc_div.sv -----
// restoring divider, one quotient bit per cycle, overflow flag marks a quotient that does not fit
// depends on lahpc_pkg
module lahpc_div #(
	parameter int CW = lahpc_pkg::CountWidthDef
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [CW+16:0]                     num,
	input  logic [CW:0]                        den,
	output logic [lahpc_pkg::QuoWidth-1:0]     quo,
	output lahpc_pkg::div_stat_t               stat
);
	import lahpc_pkg::*;

	localparam int DW   = CW + 1;
	localparam int RW   = DW + QuoWidth;
	localparam int CntW = $clog2(QuoWidth);

	logic                busy_q;
	logic                done_q;
	logic [CntW-1:0]     cnt_q;
	logic [RW-1:0]       rem_q;
	logic [RW-1:0]       dsh_q;
	logic [QuoWidth-1:0] quo_q;
	logic                ovf_q;
	logic                fits;

	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(QuoWidth - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RW'(num);
			dsh_q <= RW'(den) << (QuoWidth - 1);
			ovf_q <= {den, {QuoWidth{1'b0}}} <= RW'(num);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QuoWidth-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quo      = quo_q;
	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;

endmodule

// ----- tb/sv/linear_axis_homing_position_controller_unit_tb.sv -----
// testbench of the rail homing and position controller: directed table, then random
// sequences that home the rail and move it, each result checked against a built-in predictor
// depends on lahpc_pkg and linear_axis_homing_position_controller_unit
module linear_axis_homing_position_controller_unit_tb;
	import lahpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 20000;

	// one request as offered to the block
	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] count;
		logic               ret_sw;
		logic               ext_sw;
		logic [31:0]        now;
		logic [16:0]        target;
	} rail_req_t;

	// one result as reported by the block
	typedef struct {
		logic signed [15:0] drive;
		logic [2:0]         mode;
		logic               calibrated;
		logic [16:0]        pos;
	} rail_res_t;

	// directed row: request plus an optional typed-in result
	typedef struct {
		rail_req_t req;
		logic      has_res;
		rail_res_t res;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] op = OP_TICK;
	logic signed [31:0] encoder_count = '0;
	logic retract_switch = 1'b0;
	logic extend_switch = 1'b0;
	logic [31:0] now_ms = '0;
	logic [16:0] target_position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] rail_drive;
	logic [2:0] mode;
	logic is_calibrated;
	logic [16:0] position;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = CFG_CAL_SPEED;
	logic [15:0] cfg_data = '0;

	linear_axis_homing_position_controller_unit uut (.*);

	// predictor copy of configuration and state
	logic [14:0] p_cal_speed, p_max_speed;
	logic [15:0] p_gain, p_tol, p_stall_to;
	mode_t p_mode;
	logic [1:0] p_phase;
	logic p_tried_rev, p_calibrated;
	logic [16:0] p_setpoint;
	longint p_low, p_high, p_last_count;
	logic [31:0] p_last_time;
	int p_drive;

	rail_res_t expected_q[$];
	int failures = 0;
	int idle_pct = 0;     // sender gap percentage
	int stall_pct = 0;    // receiver stall percentage
	bit hold_off = 1'b0;  // long receiver hold-off request
	int quiet_cycles = 0;
	rail_req_t req;
	directed_row_t rows[$];

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------- predictor ----------------

	// normalized error, range positive, truncates toward zero and clamps to 2^24
	function automatic longint norm_error(longint diff, longint range);
		longint q;
		q = (diff * 65536) / range;
		if (q > 64'sd16777216) q = 64'sd16777216;
		if (q < -64'sd16777216) q = -64'sd16777216;
		return q;
	endfunction

	function automatic longint abs_l(longint v);
		return v < 0 ? -v : v;
	endfunction

	// proportional drive saturated to limit
	function automatic int prop_drive(longint e, longint limit);
		longint p;
		p = (abs_l(e) * longint'(p_gain)) >>> 9;
		if (p > limit) p = limit;
		return e < 0 ? -int'(p) : int'(p);
	endfunction

	task automatic homing_step(longint cur, logic rs, logic es, logic [31:0] now);
		logic stalled;
		longint range, e;
		if (cur != p_last_count) begin
			p_last_count = cur;
			p_last_time = now;
		end
		stalled = (now - p_last_time) >= {16'd0, p_stall_to};
		if (p_phase == PH_EXTEND) begin
			if (es) begin
				p_high = cur;
				if (p_high <= p_low) begin
					p_drive = 0;
					p_mode = MODE_FAULT;
				end else begin
					p_phase = PH_HOME;
					p_setpoint = '0;
					p_drive = -int'(p_cal_speed);
				end
			end else begin
				p_drive = p_cal_speed;
				if (stalled) begin
					p_drive = 0;
					p_mode = MODE_FAULT;
				end
			end
		end else if (p_phase == PH_HOME) begin
			range = p_high - p_low;
			if (rs) begin
				p_calibrated = 1'b1;
				p_drive = 0;
				p_mode = MODE_IDLE;
			end else if (range <= 0) begin
				p_drive = 0;
				p_mode = MODE_FAULT;
			end else begin
				e = norm_error(p_low - cur, range);
				p_drive = prop_drive(e, p_cal_speed);
				if (abs_l(e) < p_tol) begin
					p_calibrated = 1'b1;
					p_drive = 0;
					p_mode = MODE_IDLE;
				end
			end
		end else begin
			// seek retract, also the unused phase code
			if (rs) begin
				p_low = cur;
				p_phase = PH_EXTEND;
				p_tried_rev = 1'b0;
				p_last_time = now;
				p_drive = p_cal_speed;
			end else begin
				p_drive = -int'(p_cal_speed);
				if (stalled) begin
					if (!p_tried_rev) begin
						p_tried_rev = 1'b1;
						p_low = cur;
						p_phase = PH_EXTEND;
						p_last_time = now;
						p_drive = p_cal_speed;
					end else begin
						p_drive = 0;
						p_mode = MODE_FAULT;
					end
				end
			end
		end
	endtask

	task automatic moving_step(longint cur);
		longint range, tgt, e;
		range = p_high - p_low;
		if (range <= 0) begin
			p_drive = 0;
			p_mode = MODE_FAULT;
		end else begin
			tgt = p_low + ((longint'(p_setpoint) * range) >>> 16);
			e = norm_error(tgt - cur, range);
			if (abs_l(e) < p_tol) begin
				p_drive = 0;
				p_mode = MODE_IDLE;
			end else begin
				p_drive = prop_drive(e, p_max_speed);
			end
		end
	endtask

	function automatic logic [16:0] rail_position(longint cur);
		longint range, q;
		range = p_high - p_low;
		if (!p_calibrated || range == 0) return '0;
		q = ((cur - p_low) * 65536) / range;
		if (q < 0) q = 0;
		if (q > 65536) q = 65536;
		return q[16:0];
	endfunction

	task automatic predict_rail(rail_req_t r, output rail_res_t res);
		longint cur;
		cur = longint'(r.count);
		case (r.op)
			OP_TICK: begin
				if (p_mode != MODE_UNINIT) begin
					if (r.ret_sw && p_drive < 0) p_drive = 0;
					if (r.ext_sw && p_drive > 0) p_drive = 0;
				end
				if (p_mode == MODE_CAL) homing_step(cur, r.ret_sw, r.ext_sw, r.now);
				else if (p_mode == MODE_MOVING) moving_step(cur);
			end
			OP_INIT: begin
				if (p_mode != MODE_CAL) begin
					p_phase = PH_RETRACT;
					p_tried_rev = 1'b0;
					p_last_count = cur;
					p_last_time = r.now;
					p_mode = MODE_CAL;
				end
			end
			OP_SETPOS: begin
				if (p_calibrated) begin
					p_setpoint = r.target > PosOne ? PosOne : r.target;
					if (p_mode == MODE_IDLE || p_mode == MODE_MOVING) p_mode = MODE_MOVING;
				end
			end
			OP_STOP: begin
				p_drive = 0;
				if (p_mode == MODE_MOVING) p_mode = MODE_IDLE;
			end
			OP_RESET: begin
				p_drive = 0;
				p_mode = MODE_UNINIT;
				p_calibrated = 1'b0;
				p_setpoint = '0;
				p_low = 0;
				p_high = 0;
			end
			default: ;  // unknown op leaves everything alone
		endcase
		res.drive = p_drive[15:0];
		res.mode = p_mode;
		res.calibrated = p_calibrated;
		res.pos = rail_position(cur);
	endtask

	// ---------------- driving ----------------

	// offer one request and wait for it to be taken, expectation queued on acceptance
	task automatic send_request(rail_req_t r);
		rail_res_t res;
		@(posedge clk);
		while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		op <= r.op;
		encoder_count <= r.count;
		retract_switch <= r.ret_sw;
		extend_switch <= r.ext_sw;
		now_ms <= r.now;
		target_position <= r.target;
		do @(posedge clk); while (in_stall);
		predict_rail(r, res);
		expected_q.push_back(res);
		in_valid <= 1'b0;
	endtask

	// wait for the block to drain before a register write
	task automatic wait_drained();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CAL_SPEED: p_cal_speed = value[14:0];
			CFG_MAX_SPEED: p_max_speed = value[14:0];
			CFG_GAIN:      p_gain = value;
			CFG_TOLERANCE: p_tol = value;
			CFG_STALL_TO:  p_stall_to = value;
			default: ;
		endcase
	endtask

	function automatic rail_req_t make_req(logic [2:0] o, longint cnt, logic rs, logic es,
			longint t, longint tgt);
		rail_req_t r;
		r.op = o;
		r.count = cnt[31:0];
		r.ret_sw = rs;
		r.ext_sw = es;
		r.now = t[31:0];
		r.target = tgt[16:0];
		return r;
	endfunction

	function automatic rail_res_t make_res(longint d, mode_t m, logic c, longint p);
		rail_res_t r;
		r.drive = d[15:0];
		r.mode = m;
		r.calibrated = c;
		r.pos = p[16:0];
		return r;
	endfunction

	function automatic rail_req_t random_noise(logic [31:0] now);
		rail_req_t r;
		r.op = $urandom_range(7, 0);
		r.count = $urandom;
		r.ret_sw = $urandom_range(1, 0);
		r.ext_sw = $urandom_range(1, 0);
		r.now = ($urandom_range(3, 0) == 0) ? $urandom : now;
		r.target = $urandom_range(131071, 0);
		return r;
	endfunction

	// a homing run: home, seek the far end, return, then several moves; at times a bad range, a stall or a reset
	task automatic homing_sequence(int n_moves, output int sent);
		logic [31:0] t;
		longint lo, hi, cur;
		int steps;
		t = $urandom;
		lo = $signed($urandom) >>> $urandom_range(31, 1);
		hi = lo + $urandom_range(4000, 1);
		if ($urandom_range(15, 0) == 0) hi = lo - $urandom_range(5, 0); // bad range
		sent = 0;
		send_request(make_req(OP_INIT, lo + $urandom_range(500, 0), 0, 0, t, 0));
		sent++;
		cur = lo + $urandom_range(300, 0);
		steps = $urandom_range(4, 1);
		for (int i = 0; i < steps; i++) begin
			t += $urandom_range(30, 1);
			cur -= $urandom_range(50, 0);
			send_request(make_req(OP_TICK, cur, 0, 0, t, $urandom));
			sent++;
		end
		if ($urandom_range(7, 0) == 0) begin
			// stall while seeking retract
			t += p_stall_to + $urandom_range(5, 0);
			send_request(make_req(OP_TICK, cur, 0, 0, t, 0));
			sent++;
		end
		t += 3;
		send_request(make_req(OP_TICK, lo, 1, 0, t, 0));
		sent++;
		cur = lo;
		for (int i = 0; i < steps; i++) begin
			t += $urandom_range(30, 1);
			cur += $urandom_range(100, 1);
			send_request(make_req(OP_TICK, cur, 0, 0, t, 0));
			sent++;
		end
		t += 2;
		send_request(make_req(OP_TICK, hi, 0, 1, t, 0));
		sent++;
		cur = hi;
		for (int i = 0; i < 6; i++) begin
			t += 5;
			cur = cur - (cur - lo) / 2 - $urandom_range(2, 0);
			send_request(make_req(OP_TICK, cur, ($urandom_range(5, 0) == 0), 0, t, 0));
			sent++;
		end
		for (int m = 0; m < n_moves; m++) begin
			send_request(make_req(OP_SETPOS, cur, 0, 0, t, $urandom_range(70000, 0)));
			sent++;
			for (int i = 0; i < 5; i++) begin
				t += 1;
				cur = lo + ($signed($urandom_range(200, 0)) - 50) * (hi - lo) / 100;
				send_request(make_req(OP_TICK, cur, ($urandom_range(9, 0) == 0),
					($urandom_range(9, 0) == 0), t, 0));
				sent++;
			end
			if ($urandom_range(5, 0) == 0) begin
				send_request(make_req(OP_STOP, cur, 0, 0, t, 0));
				sent++;
			end
		end
		if ($urandom_range(3, 0) == 0) begin
			send_request(make_req(OP_RESET, cur, 0, 0, t, 0));
			sent++;
		end
	endtask

	// ---------------- receiver and checking ----------------

	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= (stall_pct != 0 && $urandom_range(99, 0) < stall_pct);
	end

	always @(posedge clk) begin
		rail_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: drive %0d mode %0d", $realtime,
					rail_drive, mode);
				failures++;
			end else begin
				want = expected_q.pop_front();
				if (rail_drive !== want.drive) begin
					$display("%0t: rail_drive expected %0d actual %0d", $realtime,
						want.drive, rail_drive);
					failures++;
				end
				if (mode !== want.mode) begin
					$display("%0t: mode expected %0d actual %0d", $realtime, want.mode, mode);
					failures++;
				end
				if (is_calibrated !== want.calibrated) begin
					$display("%0t: is_calibrated expected %0b actual %0b", $realtime,
						want.calibrated, is_calibrated);
					failures++;
				end
				if (position !== want.pos) begin
					$display("%0t: position expected %0d actual %0d", $realtime,
						want.pos, position);
					failures++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted request, result or register write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// directed rows check the typed-in result against the predictor result
	task automatic run_directed();
		rail_res_t got;
		foreach (rows[i]) begin
			send_request(rows[i].req);
			got = expected_q[$];
			if (rows[i].has_res && (got.drive !== rows[i].res.drive
					|| got.mode !== rows[i].res.mode
					|| got.calibrated !== rows[i].res.calibrated
					|| got.pos !== rows[i].res.pos)) begin
				$display("%0t: directed row %0d table drive %0d mode %0d pos %0d, predicted %0d %0d %0d",
					$realtime, i, rows[i].res.drive, rows[i].res.mode, rows[i].res.pos,
					got.drive, got.mode, got.pos);
				failures++;
			end
		end
	endtask

	initial begin
		int sent, total;
		p_cal_speed = CalSpeedRst;
		p_max_speed = MaxSpeedRst;
		p_gain = GainRst;
		p_tol = TolRst;
		p_stall_to = StallToRst;
		p_mode = MODE_UNINIT;
		p_phase = PH_RETRACT;
		p_tried_rev = 0;
		p_calibrated = 0;
		p_setpoint = 0;
		p_low = 0;
		p_high = 0;
		p_last_count = 0;
		p_last_time = 0;
		p_drive = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: after reset, unknown ops, full homing with extremes, move, stop, reset
		rows.push_back('{make_req(OP_TICK, -2147483648, 1, 1, 32'hFFFF_FFFF, 131071), 1,
			make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(3'd7, 2147483647, 0, 0, 0, 0), 1, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(3'd5, 0, 1, 1, 0, 0), 1, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_SETPOS, 5, 0, 0, 0, 65536), 1, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_INIT, 100, 0, 0, 1000, 0), 1, make_res(0, MODE_CAL, 0, 0)});
		rows.push_back('{make_req(OP_INIT, 7, 0, 0, 9, 0), 1, make_res(0, MODE_CAL, 0, 0)});
		rows.push_back('{make_req(OP_TICK, 90, 0, 0, 1010, 0), 1, make_res(-9830, MODE_CAL, 0, 0)});
		rows.push_back('{make_req(OP_TICK, 90, 0, 0, 1600, 0), 1, make_res(9830, MODE_CAL, 0, 0)});
		rows.push_back('{make_req(OP_TICK, 95, 0, 0, 1700, 0), 0, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_TICK, 1090, 0, 1, 1710, 0), 0, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_TICK, 600, 0, 0, 1720, 0), 0, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_TICK, 92, 1, 0, 1730, 0), 0, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_SETPOS, 90, 0, 0, 0, 131071), 0, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_TICK, 200, 0, 0, 1740, 0), 0, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_TICK, 2147483647, 0, 1, 1750, 0), 0, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_SETPOS, 590, 0, 0, 0, 32768), 0, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_TICK, -2147483648, 0, 0, 1760, 0), 0, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_STOP, 590, 0, 0, 0, 0), 0, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(3'd6, 590, 0, 0, 0, 0), 0, make_res(0, MODE_UNINIT, 0, 0)});
		rows.push_back('{make_req(OP_RESET, 590, 0, 0, 0, 0), 1, make_res(0, MODE_UNINIT, 0, 0)});
		// stall while seeking retract, then again while seeking extend, leads to fault
		rows.push_back('{make_req(OP_INIT, 0, 0, 0, 0, 0), 1, make_res(0, MODE_CAL, 0, 0)});
		rows.push_back('{make_req(OP_TICK, 0, 0, 0, 500, 0), 1, make_res(9830, MODE_CAL, 0, 0)});
		rows.push_back('{make_req(OP_TICK, 0, 0, 0, 1000, 0), 1, make_res(0, MODE_FAULT, 0, 0)});
		rows.push_back('{make_req(OP_INIT, -1, 0, 0, 32'hFFFF_FFF0, 0), 1, make_res(0, MODE_CAL, 0, 0)});
		rows.push_back('{make_req(OP_TICK, -1, 1, 0, 32'hFFFF_FFF5, 0), 1,
			make_res(9830, MODE_CAL, 0, 0)});
		run_directed();

		// random phases, each with its own configuration and idling mix
		total = 0;
		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 58; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 58; end
				3: begin idle_pct = 21; stall_pct = 21; end
				default: begin idle_pct = $urandom_range(1, 0) * 21; stall_pct = idle_pct; end
			endcase
			if (ph == 1) begin
				write_reg(CFG_CAL_SPEED, 16'h7FFF);
				write_reg(CFG_MAX_SPEED, 16'hFFFF);
				write_reg(CFG_GAIN, 16'hFFFF);
				write_reg(CFG_TOLERANCE, 16'h0000);
				write_reg(CFG_STALL_TO, 16'hFFFF);
			end else if (ph == 2) begin
				write_reg(CFG_CAL_SPEED, 16'h0000);
				write_reg(CFG_MAX_SPEED, 16'h0000);
				write_reg(CFG_GAIN, 16'h0000);
				write_reg(CFG_TOLERANCE, 16'hFFFF);
				write_reg(CFG_STALL_TO, 16'h0000);
			end else if (ph > 2) begin
				write_reg(CFG_CAL_SPEED, $urandom);
				write_reg(CFG_MAX_SPEED, $urandom);
				write_reg(CFG_GAIN, $urandom_range(4096, 0));
				write_reg(CFG_TOLERANCE, $urandom_range(3000, 0));
				write_reg(CFG_STALL_TO, $urandom_range(200, 0));
			end
			if (ph == 4) begin
				// long receiver hold-off while requests keep coming
				fork
					begin
						hold_off = 1'b1;
						repeat (400) @(posedge clk);
						hold_off = 1'b0;
					end
					for (int i = 0; i < 6; i++) send_request(random_noise($urandom));
				join
				total += 6;
			end
			while (total < (ph + 1) * 235) begin
				if ($urandom_range(4, 0) == 0) begin
					send_request(random_noise($urandom));
					total++;
				end else begin
					homing_sequence($urandom_range(6, 1), sent);
					total += sent;
				end
			end
		end

		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
